@@ sv/lts_pkg.sv @@
// Package for the link transfer sequencer: payload structs, codes and constants.
// No dependencies; every other file of the block imports it.
package lts_pkg;

    localparam int TIME_W    = 32;
    localparam int CNT_W     = 32;
    localparam int NUM_CNT   = 9;
    localparam int ACT_W     = 6;
    localparam int PHASE_W   = 2;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DONE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;

    localparam logic [TIME_W-1:0] HOLD_RESET    = 32'd1000;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

    // action bit positions
    localparam int ACT_ABORT   = 0;
    localparam int ACT_ASSERT  = 1;
    localparam int ACT_RELEASE = 2;
    localparam int ACT_PREPARE = 3;
    localparam int ACT_START   = 4;
    localparam int ACT_ACCEPT  = 5;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_RESET = 2'd0;
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_BUSY  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE  = 2'd3;

    // statistics counter slots
    localparam int C_ABORT_FAIL  = 0;
    localparam int C_RESET_FAIL  = 1;
    localparam int C_RESET_TOTAL = 2;
    localparam int C_UNEXPECTED  = 3;
    localparam int C_FAILURE     = 4;
    localparam int C_COMPLETED   = 5;
    localparam int C_TIMEOUT     = 6;
    localparam int C_START_FAIL  = 7;
    localparam int C_STARTED     = 8;

    typedef logic [NUM_CNT-1:0][CNT_W-1:0] lts_cnt_arr_t;
    typedef logic [NUM_CNT-1:0]            lts_bump_t;

    // counters after reset: all zero but reset_total, which starts at one
    localparam lts_cnt_arr_t CNT_RESET = lts_cnt_arr_t'(1) << (C_RESET_TOTAL * CNT_W);

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now_time;
        logic              completion_ok;
        logic              tx_request;
        logic              peer_request;
        logic              prepare_ok;
        logic              start_ok;
        logic              abort_ok;
        logic              reset_line_ok;
        logic              rx_accept_ok;
    } lts_item_t;

    typedef struct packed {
        logic              reset_held;
        logic              busy;
        logic              done_pending;
        logic              done_success;
        logic              frame_ready;
        logic [TIME_W-1:0] reset_start_time;
        logic [TIME_W-1:0] transfer_start_time;
    } lts_state_t;

    localparam lts_state_t STATE_RESET = '{
        reset_held:          1'b1,
        busy:                1'b0,
        done_pending:        1'b0,
        done_success:        1'b0,
        frame_ready:         1'b0,
        reset_start_time:    '0,
        transfer_start_time: '0
    };

    // step outcome handed from the step logic to the top level
    typedef struct packed {
        logic               ok;
        logic [ACT_W-1:0]   actions;
        logic [PHASE_W-1:0] phase;
    } lts_status_t;

endpackage

@@ sv/lts_if.sv @@
// Channel interfaces of the link transfer sequencer: item, result and config.
// Depends on lts_pkg for widths.
interface lts_item_if import lts_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now_time;
    logic              completion_ok;
    logic              tx_request;
    logic              peer_request;
    logic              prepare_ok;
    logic              start_ok;
    logic              abort_ok;
    logic              reset_line_ok;
    logic              rx_accept_ok;

    modport source (output valid, cmd, now_time, completion_ok, tx_request, peer_request,
                    prepare_ok, start_ok, abort_ok, reset_line_ok, rx_accept_ok,
                    input ready);
    modport sink (input valid, cmd, now_time, completion_ok, tx_request, peer_request,
                  prepare_ok, start_ok, abort_ok, reset_line_ok, rx_accept_ok,
                  output ready);
endinterface

interface lts_result_if import lts_pkg::*;;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [ACT_W-1:0]   actions;
    logic [PHASE_W-1:0] phase;
    logic [CNT_W-1:0]   abort_fail_count;
    logic [CNT_W-1:0]   reset_fail_count;
    logic [CNT_W-1:0]   reset_total;
    logic [CNT_W-1:0]   unexpected_count;
    logic [CNT_W-1:0]   failure_count;
    logic [CNT_W-1:0]   completed_count;
    logic [CNT_W-1:0]   timeout_count;
    logic [CNT_W-1:0]   start_fail_count;
    logic [CNT_W-1:0]   started_count;

    modport source (output valid, ok, actions, phase, abort_fail_count, reset_fail_count,
                    reset_total, unexpected_count, failure_count, completed_count,
                    timeout_count, start_fail_count, started_count,
                    input ready);
    modport sink (input valid, ok, actions, phase, abort_fail_count, reset_fail_count,
                  reset_total, unexpected_count, failure_count, completed_count,
                  timeout_count, start_fail_count, started_count,
                  output ready);
endinterface

interface lts_cfg_if import lts_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TIME_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/lts_step.sv @@
// Step logic: next state, counter bumps, actions and phase for one beat.
// Depends on lts_pkg.
module lts_step
    import lts_pkg::*;
(
    input  lts_item_t         item_in,
    input  lts_state_t        state_cur,
    input  logic [TIME_W-1:0] hold_time,
    input  logic [TIME_W-1:0] timeout_time,
    output lts_state_t        state_next,
    output lts_bump_t         bump,
    output lts_status_t       status
);

    logic [TIME_W-1:0] held_for;
    logic [TIME_W-1:0] running_for;
    logic              assert_req;
    logic              abort_good;
    logic              go;

    assign held_for    = item_in.now_time - state_cur.reset_start_time;
    assign running_for = item_in.now_time - state_cur.transfer_start_time;

    always_comb
    begin
        state_next     = state_cur;
        bump           = '0;
        status.ok      = 1'b0;
        status.actions = '0;
        assert_req     = 1'b0;
        abort_good     = 1'b1;
        go             = 1'b0;

        case (item_in.cmd)
            CMD_POLL:
            begin
                if (state_cur.reset_held)
                begin
                    if (held_for < hold_time)
                    begin
                        status.ok = 1'b1;
                    end
                    else
                    begin
                        status.actions[ACT_RELEASE] = 1'b1;
                        if (!item_in.reset_line_ok)
                        begin
                            bump[C_RESET_FAIL] = 1'b1;
                        end
                        else
                        begin
                            state_next.reset_held = 1'b0;
                            status.ok = 1'b1;
                        end
                    end
                end
                else if (state_cur.done_pending)
                begin
                    state_next.done_pending = 1'b0;
                    state_next.busy         = 1'b0;
                    if (!state_cur.done_success)
                    begin
                        bump[C_FAILURE] = 1'b1;
                    end
                    else
                    begin
                        bump[C_COMPLETED] = 1'b1;
                        status.actions[ACT_ACCEPT] = 1'b1;
                        status.ok = item_in.rx_accept_ok;
                    end
                end
                else if (state_cur.busy)
                begin
                    if (running_for <= timeout_time)
                    begin
                        status.ok = 1'b1;
                    end
                    else
                    begin
                        bump[C_TIMEOUT] = 1'b1;
                        bump[C_FAILURE] = 1'b1;
                        assert_req = 1'b1;
                    end
                end
                else
                begin
                    go = 1'b1;
                    if (!state_cur.frame_ready)
                    begin
                        if (!item_in.tx_request && !item_in.peer_request)
                        begin
                            status.ok = 1'b1;
                            go = 1'b0;
                        end
                        else
                        begin
                            status.actions[ACT_PREPARE] = 1'b1;
                            if (!item_in.prepare_ok)
                            begin
                                go = 1'b0;
                            end
                            else
                            begin
                                state_next.frame_ready = 1'b1;
                            end
                        end
                    end
                    if (go)
                    begin
                        status.actions[ACT_START] = 1'b1;
                        state_next.transfer_start_time = item_in.now_time;
                        if (!item_in.start_ok)
                        begin
                            state_next.busy         = 1'b0;
                            state_next.done_pending = 1'b0;
                            bump[C_START_FAIL] = 1'b1;
                        end
                        else
                        begin
                            state_next.busy        = 1'b1;
                            state_next.frame_ready = 1'b0;
                            bump[C_STARTED] = 1'b1;
                            status.ok = 1'b1;
                        end
                    end
                end
            end
            CMD_DONE:
            begin
                if (!state_cur.busy || state_cur.done_pending)
                begin
                    bump[C_UNEXPECTED] = 1'b1;
                end
                else
                begin
                    state_next.done_success = item_in.completion_ok;
                    state_next.done_pending = 1'b1;
                    status.ok = 1'b1;
                end
            end
            CMD_RESET:
            begin
                assert_req = 1'b1;
            end
            default:
            begin
                status.ok = 1'b0;
            end
        endcase

        // peer reset: drop any running transfer, then drive the line
        if (assert_req)
        begin
            if (state_cur.busy)
            begin
                status.actions[ACT_ABORT] = 1'b1;
                if (!item_in.abort_ok)
                begin
                    bump[C_ABORT_FAIL] = 1'b1;
                    abort_good = 1'b0;
                end
                state_next.busy         = 1'b0;
                state_next.done_pending = 1'b0;
            end
            status.actions[ACT_ASSERT] = 1'b1;
            if (!item_in.reset_line_ok)
            begin
                bump[C_RESET_FAIL] = 1'b1;
                status.ok = 1'b0;
            end
            else
            begin
                state_next.reset_held       = 1'b1;
                state_next.reset_start_time = item_in.now_time;
                bump[C_RESET_TOTAL] = 1'b1;
                status.ok = abort_good;
            end
        end

        if (state_next.reset_held)
        begin
            status.phase = PH_RESET;
        end
        else if (state_next.done_pending)
        begin
            status.phase = PH_DONE;
        end
        else if (state_next.busy)
        begin
            status.phase = PH_BUSY;
        end
        else
        begin
            status.phase = PH_IDLE;
        end
    end

endmodule

@@ sv/lts_counters.sv @@
// Nine saturating statistics counters, bumped at most once each per beat.
// Depends on lts_pkg.
module lts_counters
    import lts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  lts_bump_t    bump,
    output lts_cnt_arr_t cnt_next
);

    lts_cnt_arr_t cnt_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CNT; i++)
        begin
            if (bump[i] && (cnt_reg[i] != {CNT_W{1'b1}}))
            begin
                cnt_next[i] = cnt_reg[i] + {{(CNT_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                cnt_next[i] = cnt_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_RESET;
        end
        else if (step_en)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ sv/link_transfer_sequencer.sv @@
// Top level of the link transfer sequencer: channel registers, config and state.
// Depends on lts_pkg, lts_if, lts_step and lts_counters.
//
//  channel | modport | beat contents
//  --------+---------+---------------------------------------------------------
//  item    | sink    | cmd, now_time, completion_ok, requests, action outcomes
//  result  | source  | ok, actions, phase, nine statistics counters
//  cfg     | sink    | index (0 reset_hold_time, 1 transfer_timeout), data
//
// One item per cycle sustained while result.ready stays high; each item passes
// the item register, then the step logic into the result register.
// The step logic reads the state as the previous item left it, so back-to-back
// items chain through the state registers without bubbles.
// Reset: peer reset held from time 0, reset_total 1, both timings 1000 us.
// A stalled result holds its register; an empty item register still takes one more
// beat, then item.ready drops until the result moves.
// cfg.ready is always high.
module link_transfer_sequencer
    import lts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lts_item_if.sink           item,
    lts_result_if.source       result,
    lts_cfg_if.sink            cfg
);

    // input register stage
    logic        in_valid_reg;
    lts_item_t   item_reg;
    lts_item_t   item_bus;

    // output register stage
    logic        out_valid_reg;
    lts_status_t status_reg;
    lts_cnt_arr_t cnt_out_reg;

    // sequencer state and timing registers
    lts_state_t        state_reg;
    lts_state_t        state_next;
    logic [TIME_W-1:0] hold_reg;
    logic [TIME_W-1:0] timeout_reg;

    lts_bump_t    bump;
    lts_status_t  status;
    lts_cnt_arr_t cnt_next;
    logic         step_fire;

    // a step runs whenever an item is staged and the result slot is free or freeing
    assign step_fire  = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || step_fire;
    assign cfg.ready  = 1'b1;

    assign item_bus.cmd           = item.cmd;
    assign item_bus.now_time      = item.now_time;
    assign item_bus.completion_ok = item.completion_ok;
    assign item_bus.tx_request    = item.tx_request;
    assign item_bus.peer_request  = item.peer_request;
    assign item_bus.prepare_ok    = item.prepare_ok;
    assign item_bus.start_ok      = item.start_ok;
    assign item_bus.abort_ok      = item.abort_ok;
    assign item_bus.reset_line_ok = item.reset_line_ok;
    assign item_bus.rx_accept_ok  = item.rx_accept_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item_bus;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg    <= HOLD_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HOLD:    hold_reg    <= cfg.data;
                REG_TIMEOUT: timeout_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    lts_step u_step (
        .item_in      (item_reg),
        .state_cur    (state_reg),
        .hold_time    (hold_reg),
        .timeout_time (timeout_reg),
        .state_next   (state_next),
        .bump         (bump),
        .status       (status)
    );

    lts_counters u_counters (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_fire),
        .bump     (bump),
        .cnt_next (cnt_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            status_reg  <= status;
            cnt_out_reg <= cnt_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.ok               = status_reg.ok;
    assign result.actions          = status_reg.actions;
    assign result.phase            = status_reg.phase;
    assign result.abort_fail_count = cnt_out_reg[C_ABORT_FAIL];
    assign result.reset_fail_count = cnt_out_reg[C_RESET_FAIL];
    assign result.reset_total      = cnt_out_reg[C_RESET_TOTAL];
    assign result.unexpected_count = cnt_out_reg[C_UNEXPECTED];
    assign result.failure_count    = cnt_out_reg[C_FAILURE];
    assign result.completed_count  = cnt_out_reg[C_COMPLETED];
    assign result.timeout_count    = cnt_out_reg[C_TIMEOUT];
    assign result.start_fail_count = cnt_out_reg[C_START_FAIL];
    assign result.started_count    = cnt_out_reg[C_STARTED];

endmodule

@@ sv/lts_checker.sv @@
// Port-level checks for the link transfer sequencer, bound to the top level.
// Depends on lts_pkg and link_transfer_sequencer.
module lts_checker
    import lts_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               ok,
    input logic [ACT_W-1:0]   actions,
    input logic [PHASE_W-1:0] phase,
    input logic [CNT_W-1:0]   reset_total
);

    // a stalled result keeps its beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(actions) && $stable(phase)
            && $stable(reset_total))
        else $error("stalled result changed");

    // a rising result follows an item beat through the item and result registers
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without item");

    // a successful start leaves the transfer running
    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok && actions[ACT_START] |-> phase == PH_BUSY)
        else $error("start without transferring phase");

    // a successful reset drive leaves the peer held in reset
    a_reset_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok && actions[ACT_ASSERT] |-> phase == PH_RESET && reset_total != '0)
        else $error("reset drive without reset phase");

endmodule

bind link_transfer_sequencer lts_checker u_lts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .ok          (result.ok),
    .actions     (result.actions),
    .phase       (result.phase),
    .reset_total (result.reset_total)
);

@@ bench/link_transfer_sequencer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for link_transfer_sequencer: directed table, then random bursts.
// Depends on lts_pkg, lts_if and the block's RTL; a built-in predictor checks every result.
module link_transfer_sequencer_tb;
    import lts_pkg::*;

    localparam int unsigned RUN_LIMIT = 300_000;   // cycles before the watchdog fires
    localparam int unsigned PRINT_CAP = 40;        // mismatch lines printed before going quiet

    // cmd 3 has no meaning; the block must answer ok 0 and touch nothing
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // flag byte of a directed row: {completion_ok, local_req, peer_req, then five outcomes}
    localparam logic [7:0] F_COK   = 8'h80;
    localparam logic [7:0] F_LREQ  = 8'h40;
    localparam logic [7:0] F_PREQ  = 8'h20;
    localparam logic [7:0] F_PREP  = 8'h10;
    localparam logic [7:0] F_START = 8'h08;
    localparam logic [7:0] F_ABORT = 8'h04;
    localparam logic [7:0] F_LINE  = 8'h02;
    localparam logic [7:0] F_ACC   = 8'h01;
    localparam logic [7:0] ALL_OK  = F_PREP | F_START | F_ABORT | F_LINE | F_ACC;

    // action masks built from the package bit positions
    localparam logic [ACT_W-1:0] A_NONE    = '0;
    localparam logic [ACT_W-1:0] A_ABORT   = ACT_W'(1) << ACT_ABORT;
    localparam logic [ACT_W-1:0] A_ASSERT  = ACT_W'(1) << ACT_ASSERT;
    localparam logic [ACT_W-1:0] A_RELEASE = ACT_W'(1) << ACT_RELEASE;
    localparam logic [ACT_W-1:0] A_PREPARE = ACT_W'(1) << ACT_PREPARE;
    localparam logic [ACT_W-1:0] A_START   = ACT_W'(1) << ACT_START;
    localparam logic [ACT_W-1:0] A_ACCEPT  = ACT_W'(1) << ACT_ACCEPT;

    // one predicted result beat
    typedef struct packed {
        logic               ok;
        logic [ACT_W-1:0]   actions;
        logic [PHASE_W-1:0] phase;
        lts_cnt_arr_t       cnt;
    } link_status_t;

    // one item to send; typed rows carry ok/actions/phase written out by hand
    typedef struct packed {
        lts_item_t          item;
        logic               typed;
        logic               ok;
        logic [ACT_W-1:0]   act;
        logic [PHASE_W-1:0] ph;
    } step_row_t;

    // one random burst: register values, time step span, length, idle-free flag
    typedef struct packed {
        logic [TIME_W-1:0] hold;
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] span;
        logic [15:0]       beats;
        logic              steady;
    } link_setting_t;

    logic clk;
    logic rst_n = 1'b0;

    lts_item_if   item_if ();
    lts_result_if result_if ();
    lts_cfg_if    cfg_if ();

    link_transfer_sequencer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer's registers.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] hold_time;
    logic [TIME_W-1:0] xfer_timeout;
    logic              link_held;
    logic              xfer_busy;
    logic              done_wait;     // completion seen, resolved on next poll
    logic              done_good;
    logic              frame_staged;  // prepared frame kept across a failed start
    logic [TIME_W-1:0] hold_start;
    logic [TIME_W-1:0] xfer_start;
    lts_cnt_arr_t      stats;
    logic [ACT_W-1:0]  step_acts;

    link_status_t  pending_status [$];   // results owed by the block, oldest first
    step_row_t     dir_rows [$];
    link_setting_t bursts [$];

    logic [TIME_W-1:0] cur_time;         // microsecond clock seen by the random items
    logic              steady = 1'b0;    // no idling on either side while set
    int unsigned       mismatches = 0;
    int unsigned       result_beats = 0;
    int unsigned       cycles = 0;

    string stat_label [NUM_CNT] = '{"abort_fail_count", "reset_fail_count", "reset_total",
                                    "unexpected_count", "failure_count", "completed_count",
                                    "timeout_count", "start_fail_count", "started_count"};

    // counters stick at all ones
    function automatic void bump_stat(int slot);
        if (stats[slot] != '1)
            stats[slot] = stats[slot] + 1'b1;
    endfunction

    // drop any running transfer, then try to drive the peer reset line
    function automatic logic reset_peer(logic [TIME_W-1:0] now, logic abort_ok, logic line_ok);
        logic good;
        good = 1'b1;
        if (xfer_busy)
        begin
            step_acts[ACT_ABORT] = 1'b1;
            if (!abort_ok)
            begin
                bump_stat(C_ABORT_FAIL);
                good = 1'b0;
            end
            xfer_busy = 1'b0;
            done_wait = 1'b0;
        end
        step_acts[ACT_ASSERT] = 1'b1;
        if (!line_ok)
        begin
            // line stuck: transfer already gone, hold state untouched
            bump_stat(C_RESET_FAIL);
            return 1'b0;
        end
        link_held  = 1'b1;
        hold_start = now;
        bump_stat(C_RESET_TOTAL);
        return good;
    endfunction

    function automatic logic poll_link(lts_item_t it);
        logic [TIME_W-1:0] held_for;
        logic [TIME_W-1:0] busy_for;
        held_for = it.now_time - hold_start;    // modulo 2^32 on purpose
        busy_for = it.now_time - xfer_start;
        if (link_held)
        begin
            if (held_for < hold_time)
                return 1'b1;
            step_acts[ACT_RELEASE] = 1'b1;
            if (!it.reset_line_ok)
            begin
                bump_stat(C_RESET_FAIL);
                return 1'b0;
            end
            link_held = 1'b0;
            return 1'b1;
        end
        if (done_wait)
        begin
            done_wait = 1'b0;
            xfer_busy = 1'b0;
            if (!done_good)
            begin
                bump_stat(C_FAILURE);
                return 1'b0;
            end
            bump_stat(C_COMPLETED);
            step_acts[ACT_ACCEPT] = 1'b1;
            return it.rx_accept_ok;
        end
        if (xfer_busy)
        begin
            if (busy_for <= xfer_timeout)
                return 1'b1;
            bump_stat(C_TIMEOUT);
            bump_stat(C_FAILURE);
            return reset_peer(it.now_time, it.abort_ok, it.reset_line_ok);
        end
        if (!frame_staged)
        begin
            if (!it.tx_request && !it.peer_request)
                return 1'b1;
            step_acts[ACT_PREPARE] = 1'b1;
            if (!it.prepare_ok)
                return 1'b0;
            frame_staged = 1'b1;
        end
        step_acts[ACT_START] = 1'b1;
        xfer_start = it.now_time;
        if (!it.start_ok)
        begin
            xfer_busy = 1'b0;
            done_wait = 1'b0;
            bump_stat(C_START_FAIL);
            return 1'b0;
        end
        xfer_busy    = 1'b1;
        frame_staged = 1'b0;
        bump_stat(C_STARTED);
        return 1'b1;
    endfunction

    // apply one item to the predictor and return the result it must produce
    function automatic link_status_t advance_link(lts_item_t it);
        link_status_t s;
        step_acts = A_NONE;
        s.ok      = 1'b0;
        case (it.cmd)
            CMD_POLL:  s.ok = poll_link(it);
            CMD_DONE:
            begin
                if (!xfer_busy || done_wait)
                begin
                    // stray completion
                    bump_stat(C_UNEXPECTED);
                    s.ok = 1'b0;
                end
                else
                begin
                    done_good = it.completion_ok;
                    done_wait = 1'b1;
                    s.ok      = 1'b1;
                end
            end
            CMD_RESET: s.ok = reset_peer(it.now_time, it.abort_ok, it.reset_line_ok);
            default:   s.ok = 1'b0;
        endcase
        s.actions = step_acts;
        s.phase   = link_held ? PH_RESET : done_wait ? PH_DONE : xfer_busy ? PH_BUSY : PH_IDLE;
        s.cnt     = stats;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void add_row(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now,
                                    logic [7:0] flags, logic typed, logic ok,
                                    logic [ACT_W-1:0] act, logic [PHASE_W-1:0] ph);
        step_row_t r;
        r.item.cmd           = cmd;
        r.item.now_time      = now;
        r.item.completion_ok = flags[7];
        r.item.tx_request    = flags[6];
        r.item.peer_request  = flags[5];
        r.item.prepare_ok    = flags[4];
        r.item.start_ok      = flags[3];
        r.item.abort_ok      = flags[2];
        r.item.reset_line_ok = flags[1];
        r.item.rx_accept_ok  = flags[0];
        r.typed = typed;
        r.ok    = ok;
        r.act   = act;
        r.ph    = ph;
        dir_rows.push_back(r);
    endfunction

    // Random item. The clock mostly creeps forward; about one item in seven lands
    // right on a hold or timeout edge (one under, on, one over), a few jump anywhere.
    // Outcomes mostly succeed so transfers run end to end; noisy items flip coins.
    function automatic lts_item_t rand_item(logic [TIME_W-1:0] span);
        lts_item_t   it;
        int unsigned pick;
        int unsigned ok_pct;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            cur_time = cur_time + $urandom_range(0, span);
        else if (pick < 75)
            cur_time = (xfer_busy ? xfer_start + xfer_timeout : hold_start + hold_time)
                       + $urandom_range(0, 2) - 1;
        else if (pick < 80)
            cur_time = $urandom;
        it.now_time = cur_time;
        pick = $urandom_range(0, 99);
        it.cmd = (pick < 68) ? CMD_POLL : (pick < 90) ? CMD_DONE :
                 (pick < 96) ? CMD_RESET : CMD_UNUSED;
        ok_pct = chance(15) ? 50 : 90;
        it.completion_ok = chance(70);
        it.tx_request    = chance(50);
        it.peer_request  = chance(50);
        it.prepare_ok    = chance(ok_pct);
        it.start_ok      = chance(ok_pct);
        it.abort_ok      = chance(ok_pct);
        it.reset_line_ok = chance(ok_pct);
        it.rx_accept_ok  = chance(ok_pct);
        return it;
    endfunction

    // Send one item beat: optional idle cycles, then hold valid until ready.
    // valid stays high after the beat so back-to-back items need no second NBA.
    task automatic drive_step(input step_row_t row);
        link_status_t want;
        while (!steady && chance(9))
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid         <= 1'b1;
        item_if.cmd           <= row.item.cmd;
        item_if.now_time      <= row.item.now_time;
        item_if.completion_ok <= row.item.completion_ok;
        item_if.tx_request    <= row.item.tx_request;
        item_if.peer_request  <= row.item.peer_request;
        item_if.prepare_ok    <= row.item.prepare_ok;
        item_if.start_ok      <= row.item.start_ok;
        item_if.abort_ok      <= row.item.abort_ok;
        item_if.reset_line_ok <= row.item.reset_line_ok;
        item_if.rx_accept_ok  <= row.item.rx_accept_ok;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        // beat taken at this edge
        want = advance_link(row.item);
        if (row.typed)
        begin
            want.ok      = row.ok;
            want.actions = row.act;
            want.phase   = row.ph;
        end
        pending_status.push_back(want);
    endtask

    // Register write beat; valid is left high, the caller lowers it after the group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == REG_HOLD)
            hold_time = val;
        else
            xfer_timeout = val;
    endtask

    // stop sending and wait for every owed result; each item yields one, so the
    // block is idle once the queue is empty
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns result %0d: %s got %0h want %0h", $time, result_beats, what,
                     got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, compare every beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
        result_if.ready <= steady || !chance(9);

    always @(posedge clk)
    begin : check_result
        link_status_t want;
        lts_cnt_arr_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got[C_ABORT_FAIL]  = result_if.abort_fail_count;
            got[C_RESET_FAIL]  = result_if.reset_fail_count;
            got[C_RESET_TOTAL] = result_if.reset_total;
            got[C_UNEXPECTED]  = result_if.unexpected_count;
            got[C_FAILURE]     = result_if.failure_count;
            got[C_COMPLETED]   = result_if.completed_count;
            got[C_TIMEOUT]     = result_if.timeout_count;
            got[C_START_FAIL]  = result_if.start_fail_count;
            got[C_STARTED]     = result_if.started_count;
            if (pending_status.size() == 0)
                flag_mismatch("result beat with nothing outstanding", '0, '0);
            else
            begin
                want = pending_status.pop_front();
                if (result_if.ok !== want.ok)
                    flag_mismatch("ok", CNT_W'(result_if.ok), CNT_W'(want.ok));
                if (result_if.actions !== want.actions)
                    flag_mismatch("actions", CNT_W'(result_if.actions), CNT_W'(want.actions));
                if (result_if.phase !== want.phase)
                    flag_mismatch("phase", CNT_W'(result_if.phase), CNT_W'(want.phase));
                for (int i = 0; i < NUM_CNT; i++)
                    if (got[i] !== want.cnt[i])
                        flag_mismatch(stat_label[i], got[i], want.cnt[i]);
            end
            result_beats++;
        end
    end

    // watchdog
    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        while (cycles < RUN_LIMIT)
            @(posedge clk);
        $display("link_transfer_sequencer_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        step_row_t     row;
        link_setting_t s;

        // every block input known from time 0
        item_if.valid         = 1'b0;
        item_if.cmd           = CMD_POLL;
        item_if.now_time      = '0;
        item_if.completion_ok = 1'b0;
        item_if.tx_request    = 1'b0;
        item_if.peer_request  = 1'b0;
        item_if.prepare_ok    = 1'b0;
        item_if.start_ok      = 1'b0;
        item_if.abort_ok      = 1'b0;
        item_if.reset_line_ok = 1'b0;
        item_if.rx_accept_ok  = 1'b0;
        result_if.ready       = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_HOLD;
        cfg_if.data           = '0;

        // predictor comes up as after a good init: peer held since t=0, one reset counted
        hold_time    = HOLD_RESET;
        xfer_timeout = TIMEOUT_RESET;
        link_held    = STATE_RESET.reset_held;
        xfer_busy    = STATE_RESET.busy;
        done_wait    = STATE_RESET.done_pending;
        done_good    = STATE_RESET.done_success;
        frame_staged = STATE_RESET.frame_ready;
        hold_start   = STATE_RESET.reset_start_time;
        xfer_start   = STATE_RESET.transfer_start_time;
        stats        = '0;
        stats[C_RESET_TOTAL] = 1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk at reset timings (hold 1000, timeout 1000).
        //      cmd         now            flags                 typed ok  actions    phase
        add_row(CMD_POLL,   32'd0,         ALL_OK,                1'b1, 1'b1, A_NONE, PH_RESET);
        add_row(CMD_UNUSED, 32'd5,         ALL_OK,                1'b1, 1'b0, A_NONE, PH_RESET);
        // completion with no transfer at all
        add_row(CMD_DONE,   32'd10,        ALL_OK | F_COK,        1'b1, 1'b0, A_NONE, PH_RESET);
        // hold edge: one short, then on it with the line failing, then released
        add_row(CMD_POLL,   32'd999,       ALL_OK,                1'b1, 1'b1, A_NONE, PH_RESET);
        add_row(CMD_POLL,   32'd1000,      ALL_OK & ~F_LINE,      1'b1, 1'b0,
                A_RELEASE, PH_RESET);
        add_row(CMD_POLL,   32'd1000,      ALL_OK,                1'b1, 1'b1,
                A_RELEASE, PH_IDLE);
        add_row(CMD_POLL,   32'd1001,      ALL_OK,                1'b1, 1'b1, A_NONE, PH_IDLE);
        add_row(CMD_POLL,   32'd1002,      (ALL_OK & ~F_PREP) | F_LREQ, 1'b1, 1'b0,
                A_PREPARE, PH_IDLE);
        // failed start keeps the frame; next poll starts without preparing
        add_row(CMD_POLL,   32'd1003,      (ALL_OK & ~F_START) | F_PREQ, 1'b1, 1'b0,
                A_PREPARE | A_START, PH_IDLE);
        add_row(CMD_POLL,   32'd1004,      ALL_OK,                1'b1, 1'b1, A_START, PH_BUSY);
        add_row(CMD_DONE,   32'd1005,      ALL_OK | F_COK,        1'b1, 1'b1, A_NONE, PH_DONE);
        // second completion while one is pending
        add_row(CMD_DONE,   32'd1006,      ALL_OK | F_COK,        1'b1, 1'b0, A_NONE, PH_DONE);
        add_row(CMD_POLL,   32'd1007,      ALL_OK & ~F_ACC,       1'b1, 1'b0,
                A_ACCEPT, PH_IDLE);
        add_row(CMD_POLL,   32'd1008,      ALL_OK | F_LREQ | F_PREQ, 1'b0, 1'b0,
                A_NONE, PH_IDLE);
        add_row(CMD_DONE,   32'd1009,      ALL_OK,                1'b0, 1'b0, A_NONE, PH_IDLE);
        add_row(CMD_POLL,   32'd1010,      ALL_OK,                1'b0, 1'b0, A_NONE, PH_IDLE);
        add_row(CMD_POLL,   32'd1011,      ALL_OK | F_PREQ,       1'b0, 1'b0, A_NONE, PH_IDLE);
        // timeout edge: exactly 1000 us still runs, 1001 aborts (abort fails) and resets
        add_row(CMD_POLL,   32'd2011,      ALL_OK,                1'b1, 1'b1, A_NONE, PH_BUSY);
        add_row(CMD_POLL,   32'd2012,      ALL_OK & ~F_ABORT,     1'b1, 1'b0,
                A_ABORT | A_ASSERT, PH_RESET);
        add_row(CMD_RESET,  32'd2013,      ALL_OK & ~F_LINE,      1'b1, 1'b0,
                A_ASSERT, PH_RESET);
        add_row(CMD_POLL,   32'd3012,      ALL_OK,                1'b0, 1'b0, A_NONE, PH_IDLE);
        add_row(CMD_POLL,   32'd3013,      ALL_OK | F_LREQ,       1'b0, 1'b0, A_NONE, PH_IDLE);
        // reset request mid-transfer with a dead line: transfer dropped, not held
        add_row(CMD_RESET,  32'd3014,      ALL_OK & ~F_LINE,      1'b1, 1'b0,
                A_ABORT | A_ASSERT, PH_IDLE);
        // hold window that straddles the 2^32 wrap
        add_row(CMD_RESET,  32'hFFFF_FF00, ALL_OK,                1'b1, 1'b1,
                A_ASSERT, PH_RESET);
        add_row(CMD_POLL,   32'h0000_02E0, ALL_OK,                1'b1, 1'b1, A_NONE, PH_RESET);
        add_row(CMD_POLL,   32'h0000_0300, ALL_OK,                1'b1, 1'b1,
                A_RELEASE, PH_IDLE);

        foreach (dir_rows[i])
            drive_step(dir_rows[i]);
        cur_time = dir_rows[dir_rows.size() - 1].item.now_time;

        // Random bursts: timings of one, zero timings, an idle-free stretch,
        // back to reset values, maximum timings, then random small ones.
        bursts.push_back('{hold: 32'd1,  timeout: 32'd1,  span: 32'd2,  beats: 16'd150,
                           steady: 1'b0});
        bursts.push_back('{hold: 32'd0,  timeout: 32'd0,  span: 32'd1,  beats: 16'd120,
                           steady: 1'b0});
        bursts.push_back('{hold: 32'd40, timeout: 32'd60, span: 32'd20, beats: 16'd200,
                           steady: 1'b1});
        bursts.push_back('{hold: HOLD_RESET, timeout: TIMEOUT_RESET, span: 32'd300,
                           beats: 16'd180, steady: 1'b0});
        bursts.push_back('{hold: '1, timeout: '1, span: 32'd1000, beats: 16'd60,
                           steady: 1'b0});
        bursts.push_back('{hold: $urandom_range(1, 500), timeout: $urandom_range(1, 500),
                           span: 32'd100, beats: 16'd240, steady: 1'b0});

        foreach (bursts[b])
        begin
            s = bursts[b];
            settle();
            write_reg(REG_HOLD, s.hold);
            write_reg(REG_TIMEOUT, s.timeout);
            cfg_if.valid <= 1'b0;
            steady = s.steady;
            for (int n = 0; n < s.beats; n++)
            begin
                row      = '0;
                row.item = rand_item(s.span);
                drive_step(row);
            end
        end
        settle();
        steady = 1'b0;

        // keep clocking in case a stray beat follows the last result
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("link_transfer_sequencer_tb: clean");
        else
            $display("link_transfer_sequencer_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
sv/lts_pkg.sv
sv/lts_if.sv
sv/lts_step.sv
sv/lts_counters.sv
sv/link_transfer_sequencer.sv
sv/lts_checker.sv
bench/link_transfer_sequencer_tb.sv
